/* rtl/core/sfr_pkg.sv */
// Shared types and constants for the sync/length framed reply receiver.
`default_nettype none

package sfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 17;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [BYTE_W-1:0] SYNC_BYTE_RST    = 8'h7E;
  localparam logic [BYTE_W-1:0] ERR_STATUS_RST   = 8'h42;
  localparam logic [BYTE_W-1:0] XOR_SEED         = 8'hFF;
  localparam logic [INDEX_W-1:0] STATUS_POS      = 17'd5;
  localparam logic [INDEX_W-1:0] FOLD_START_POS  = 17'd4;
  localparam logic [15:0]        MIN_LENGTH      = 16'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_STATUS = 8'd1;

  typedef enum logic [2:0] {
    OC_IN_FRAME   = 3'd0,
    OC_OK         = 3'd1,
    OC_BAD_SYNC   = 3'd2,
    OC_CHECKSUM   = 3'd3,
    OC_DEVICE_ERR = 3'd4,
    OC_LENGTH_ERR = 3'd5
  } outcome_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]  frame_status;
    outcome_t           outcome;
    logic               end_of_frame;
  } sfr_result_t;

endpackage

`default_nettype wire

/* rtl/core/sfr_parser.sv */
// Frame parser: phase, position and checksum state, and the result for each byte.
`default_nettype none

module sfr_parser
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic [BYTE_W-1:0] sync_byte,
  input  wire logic [BYTE_W-1:0] error_status_code,
  output sfr_result_t            result
);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t             phase_r,       phase_nxt;
  logic [INDEX_W-1:0] total_r,       total_nxt;
  logic [INDEX_W-1:0] pos_r,         pos_nxt;
  logic [BYTE_W-1:0]  xor_r,         xor_nxt;
  logic [BYTE_W-1:0]  sum_r,         sum_nxt;
  logic [BYTE_W-1:0]  status_r,      status_nxt;
  logic               xor_ok_r,      xor_ok_nxt;

  logic [INDEX_W:0]   pos_ext;
  logic [INDEX_W:0]   total_ext;
  logic [15:0]        len;
  logic [BYTE_W-1:0]  status_eff;
  logic [BYTE_W-1:0]  want;

  assign pos_ext   = {1'b0, pos_r};
  assign total_ext = {1'b0, total_r};
  assign len       = {total_r[15:8], rx_byte};
  assign status_eff = (pos_r == STATUS_POS) ? rx_byte : status_r;
  assign want      = sum_r + xor_r;

  always_comb begin
    phase_nxt  = phase_r;
    total_nxt  = total_r;
    pos_nxt    = pos_r;
    xor_nxt    = xor_r;
    sum_nxt    = sum_r;
    status_nxt = status_r;
    xor_ok_nxt = xor_ok_r;

    result.data_byte    = rx_byte;
    result.byte_index   = pos_r;
    result.frame_status = '0;
    result.outcome      = OC_IN_FRAME;
    result.end_of_frame = 1'b0;

    case (phase_r)
      PH_HUNT: begin
        result.byte_index = '0;
        if (rx_byte != sync_byte) begin
          result.outcome      = OC_BAD_SYNC;
          result.end_of_frame = 1'b1;
        end else begin
          xor_nxt    = XOR_SEED;
          sum_nxt    = '0;
          status_nxt = '0;
          xor_ok_nxt = 1'b0;
          total_nxt  = '0;
          pos_nxt    = INDEX_W'(1);
          phase_nxt  = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (pos_r == INDEX_W'(1)) begin
          total_nxt = {1'b0, rx_byte, 8'h00};
          pos_nxt   = INDEX_W'(2);
        end else if (len < MIN_LENGTH) begin
          result.outcome      = OC_LENGTH_ERR;
          result.end_of_frame = 1'b1;
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
          total_nxt = '0;
        end else begin
          total_nxt = {1'b0, len} + INDEX_W'(2);
          pos_nxt   = INDEX_W'(3);
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (pos_r == STATUS_POS) begin
          status_nxt = rx_byte;
        end
        if (pos_r >= FOLD_START_POS && pos_ext + (INDEX_W+1)'(3) <= total_ext) begin
          xor_nxt = xor_r ^ rx_byte;
          sum_nxt = sum_r + rx_byte;
        end
        if (pos_ext + (INDEX_W+1)'(2) == total_ext) begin
          xor_ok_nxt = (rx_byte == xor_r);
        end
        if (pos_ext + (INDEX_W+1)'(1) >= total_ext) begin
          result.frame_status = status_eff;
          result.end_of_frame = 1'b1;
          if (!xor_ok_r || rx_byte != want) begin
            result.outcome = OC_CHECKSUM;
          end else if (status_eff == error_status_code) begin
            result.outcome = OC_DEVICE_ERR;
          end else begin
            result.outcome = OC_OK;
          end
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
        end else begin
          pos_nxt = pos_r + INDEX_W'(1);
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        pos_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      total_r  <= '0;
      pos_r    <= '0;
      xor_r    <= XOR_SEED;
      sum_r    <= '0;
      status_r <= '0;
      xor_ok_r <= 1'b0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      total_r  <= total_nxt;
      pos_r    <= pos_nxt;
      xor_r    <= xor_nxt;
      sum_r    <= sum_nxt;
      status_r <= status_nxt;
      xor_ok_r <= xor_ok_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sync_length_frame_receiver.sv */
// Top level of the sync/length framed reply receiver: config registers and result register.
//
//   channel | direction | payload                                         | handshake
//   in_     | input     | rx_byte                                         | in_valid/in_ready
//   out_    | output    | data_byte, byte_index, frame_status, outcome,   | out_valid/out_ready
//           |           | end_of_frame                                    |
//   cfg_    | input     | index, data                                     | cfg_valid/cfg_ready
//
// One item per cycle unless out_ready stalls; an accepted byte's result shows in the next cycle.
// The only storage on the path is the parser state and the result register.
// Reset returns the parser to hunting and loads the default sync and error codes.
// A stalled result holds in the result register; a new item is taken in the same
// cycle the held one leaves.
`default_nettype none

module sync_length_frame_receiver
  import sfr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [BYTE_W-1:0]         out_data_byte,
  output logic [INDEX_W-1:0]        out_byte_index,
  output logic [BYTE_W-1:0]         out_frame_status,
  output logic [2:0]                out_outcome,
  output logic                      out_end_of_frame,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  logic [BYTE_W-1:0] sync_byte_r;
  logic [BYTE_W-1:0] err_status_r;
  logic              out_valid_r;
  sfr_result_t       result;
  sfr_result_t       result_r;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r  <= SYNC_BYTE_RST;
      err_status_r <= ERR_STATUS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SYNC_BYTE:  sync_byte_r  <= cfg_data;
        REG_ERR_STATUS: err_status_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sfr_parser u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .advance           (accept),
    .rx_byte           (in_rx_byte),
    .sync_byte         (sync_byte_r),
    .error_status_code (err_status_r),
    .result            (result)
  );

  // advance the result register on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = result_r.data_byte;
  assign out_byte_index   = result_r.byte_index;
  assign out_frame_status = result_r.frame_status;
  assign out_outcome      = result_r.outcome;
  assign out_end_of_frame = result_r.end_of_frame;

endmodule

`default_nettype wire

/* rtl/core/sfr_checker.sv */
// Port-level checks for the sync/length framed reply receiver, bound to the top level.
`default_nettype none

module sfr_checker
  import sfr_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [BYTE_W-1:0]    out_data_byte,
  input wire logic [INDEX_W-1:0]   out_byte_index,
  input wire logic [BYTE_W-1:0]    out_frame_status,
  input wire logic [2:0]           out_outcome,
  input wire logic                 out_end_of_frame
);

  a_bad_sync_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OC_BAD_SYNC |-> out_end_of_frame && out_byte_index == '0)
    else $error("bad sync item without end of frame or with nonzero index");

  a_length_err_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OC_LENGTH_ERR |-> out_end_of_frame && out_byte_index == 17'd2)
    else $error("length error not on the low length byte");

  a_eof_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_end_of_frame == (out_outcome != OC_IN_FRAME)))
    else $error("end of frame and outcome disagree");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == OC_IN_FRAME || out_outcome == OC_BAD_SYNC ||
                  out_outcome == OC_LENGTH_ERR) |-> out_frame_status == '0)
    else $error("frame status shown outside a completed frame");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) &&
                                $stable(out_byte_index) && $stable(out_outcome))
    else $error("stalled result item changed");

endmodule

bind sync_length_frame_receiver sfr_checker u_sfr_checker (.*);

`default_nettype wire

/* bench/sync_length_frame_receiver_tb.sv */
// Self-checking testbench for the sync/length framed reply receiver: parse model and scoreboard.
module sync_length_frame_receiver_tb;
  import sfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 8'hFF;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_BODY
  } parse_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BYTE_W-1:0] out_data_byte;
  logic [INDEX_W-1:0] out_byte_index;
  logic [BYTE_W-1:0] out_frame_status;
  logic [2:0] out_outcome;
  logic out_end_of_frame;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;

  sync_length_frame_receiver DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_status (out_frame_status),
    .out_outcome      (out_outcome),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // parser model state
  logic [BYTE_W-1:0]  pred_sync     = SYNC_BYTE_RST;
  logic [BYTE_W-1:0]  pred_err_code = ERR_STATUS_RST;
  parse_phase_t       rx_phase      = PH_HUNT;
  logic [INDEX_W-1:0] frame_total   = '0;
  logic [INDEX_W-1:0] rx_pos        = '0;
  logic [BYTE_W-1:0]  xor_fold      = XOR_SEED;
  logic [BYTE_W-1:0]  sum_fold      = '0;
  logic [BYTE_W-1:0]  status_hold   = '0;
  logic               xor_match     = 1'b0;

  logic [BYTE_W-1:0] byte_queue[$];
  sfr_result_t expected_results[$];
  int unsigned bytes_queued = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_left = 0;
  logic in_taken = 1'b0;

  function automatic sfr_result_t parse_rx_byte(input logic [BYTE_W-1:0] b);
    sfr_result_t r;
    int unsigned p;
    int unsigned total;
    logic [15:0] len;
    logic [BYTE_W-1:0] want;
    r = '0;
    r.data_byte = b;
    r.outcome = OC_IN_FRAME;
    p = rx_pos;
    total = frame_total;
    case (rx_phase)
      PH_HUNT: begin
        if (b != pred_sync) begin
          r.outcome = OC_BAD_SYNC;
          r.end_of_frame = 1'b1;
        end else begin
          xor_fold = XOR_SEED;
          sum_fold = '0;
          status_hold = '0;
          xor_match = 1'b0;
          frame_total = '0;
          rx_pos = 17'd1;
          rx_phase = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (p == 1) begin
          frame_total = {1'b0, b, 8'h00};
          rx_pos = 17'd2;
          r.byte_index = 17'd1;
        end else begin
          len = {frame_total[15:8], b};
          r.byte_index = 17'd2;
          if (len < MIN_LENGTH) begin
            rx_phase = PH_HUNT;
            rx_pos = '0;
            frame_total = '0;
            r.outcome = OC_LENGTH_ERR;
            r.end_of_frame = 1'b1;
          end else begin
            frame_total = {1'b0, len} + 17'd2;
            rx_pos = 17'd3;
            rx_phase = PH_BODY;
          end
        end
      end
      default: begin
        r.byte_index = rx_pos;
        if (p == STATUS_POS) status_hold = b;
        if (p >= FOLD_START_POS && p + 3 <= total) begin
          xor_fold = xor_fold ^ b;
          sum_fold = sum_fold + b;
        end
        if (p + 2 == total) xor_match = (b == xor_fold);
        if (p + 1 >= total) begin
          want = sum_fold + xor_fold;
          if (!xor_match || b != want) r.outcome = OC_CHECKSUM;
          else if (status_hold == pred_err_code) r.outcome = OC_DEVICE_ERR;
          else r.outcome = OC_OK;
          r.frame_status = status_hold;
          r.end_of_frame = 1'b1;
          rx_phase = PH_HUNT;
          rx_pos = '0;
        end else begin
          rx_pos = rx_pos + 17'd1;
        end
      end
    endcase
    return r;
  endfunction

  // scoreboard, register model and item acceptance
  always @(posedge clk) begin
    sfr_result_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (error_count < 10)
            $display("unexpected result item: data %h index %0d outcome %0d",
                     out_data_byte, out_byte_index, out_outcome);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_byte !== exp_r.data_byte || out_byte_index !== exp_r.byte_index ||
              out_frame_status !== exp_r.frame_status || out_outcome !== exp_r.outcome ||
              out_end_of_frame !== exp_r.end_of_frame) begin
            if (error_count < 10)
              $display({"mismatch (exp/got): data %h/%h index %0d/%0d status %h/%h ",
                        "outcome %0d/%0d eof %b/%b"},
                       exp_r.data_byte, out_data_byte, exp_r.byte_index, out_byte_index,
                       exp_r.frame_status, out_frame_status, exp_r.outcome, out_outcome,
                       exp_r.end_of_frame, out_end_of_frame);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_BYTE:  pred_sync = cfg_data;
          REG_ERR_STATUS: pred_err_code = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results = {expected_results, parse_rx_byte(in_rx_byte)};
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= byte_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sync_length_frame_receiver verification failed");
      $finish;
    end
  end

  function automatic void push_rx(input logic [BYTE_W-1:0] b);
    byte_queue = {byte_queue, b};
    bytes_queued++;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_frame(input logic [15:0] len, input bit dev_err, input bit corrupt);
    logic [BYTE_W-1:0] frame[$];
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] v;
    int unsigned total;
    int unsigned i;
    int unsigned hit;
    total = len + 2;
    x = XOR_SEED;
    s = '0;
    frame = {frame, pred_sync};
    frame = {frame, len[15:8]};
    frame = {frame, len[7:0]};
    frame = {frame, BYTE_W'($urandom_range(0, 255))};
    for (i = 4; i + 3 <= total; i++) begin
      v = (i == STATUS_POS && dev_err) ? pred_err_code : BYTE_W'($urandom_range(0, 255));
      x = x ^ v;
      s = s + v;
      frame = {frame, v};
    end
    frame = {frame, x};
    frame = {frame, BYTE_W'(s + x)};
    if (corrupt) begin
      hit = $urandom_range(4, total - 1);
      if (hit == STATUS_POS) hit = total - 1;
      frame[hit] = frame[hit] ^ (8'h01 << $urandom_range(0, 7));
    end
    foreach (frame[k]) push_rx(frame[k]);
  endtask

  task automatic queue_random_traffic(input int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    int unsigned n;
    logic [BYTE_W-1:0] v;
    logic [15:0] len;
    target = bytes_queued + n_items;
    while (bytes_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) len = 16'($urandom_range(200, 300));
      else len = 16'($urandom_range(4, 24));
      if (pick < 68) begin
        queue_frame(len, $urandom_range(0, 3) == 0, 1'b0);
      end else if (pick < 80) begin
        queue_frame(len, $urandom_range(0, 3) == 0, 1'b1);
      end else if (pick < 88) begin
        push_rx(pred_sync);
        push_rx(8'h00);
        push_rx(BYTE_W'($urandom_range(0, 3)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          do v = BYTE_W'($urandom_range(0, 255)); while (v == pred_sync);
          push_rx(v);
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 15;
    rx_idle_pct = 62;
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(pred_sync);
    push_rx(8'h00);
    push_rx(8'h03);
    queue_frame(16'd4, 1'b0, 1'b0);
    queue_frame(16'd6, 1'b1, 1'b0);
    queue_frame(16'd6, 1'b1, 1'b1);
    queue_random_traffic(450);
    wait_drained();

    write_reg(REG_SYNC_BYTE, 8'h00);
    write_reg(REG_ERR_STATUS, 8'hFF);
    write_reg(REG_SPARE_LOW, 8'h55);
    write_reg(REG_SPARE_TOP, 8'hAA);
    tx_idle_pct = 62;
    rx_idle_pct = 15;
    queue_frame(16'd4, 1'b0, 1'b0);
    queue_random_traffic(450);
    wait_drained();

    write_reg(REG_SYNC_BYTE, 8'hFF);
    write_reg(REG_ERR_STATUS, 8'h00);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_traffic(450);
    @(posedge clk);
    rx_hold_left = HOLD_CYCLES;
    queue_frame(16'd40, $urandom_range(0, 1) == 1, 1'b0);
    wait_drained();

    write_reg(REG_SYNC_BYTE, BYTE_W'($urandom_range(0, 255)));
    write_reg(REG_ERR_STATUS, BYTE_W'($urandom_range(0, 255)));
    queue_random_traffic(150);
    wait_drained();

    if (expected_results.size() != 0) begin
      $display("%0d result items never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("sync_length_frame_receiver verification clean");
    end else begin
      $display("sync_length_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
